@@ rtl/tiled_dirty_rect_tracker_assert.svh @@
// Assertion macros for the tracker RTL.
// TDRT_ASSERT checks a property on every rising clock edge outside reset.
// TDRT_ASSERT_IMP checks a same-cycle implication.
// TDRT_ASSERT_NXT checks a next-cycle implication.
`ifndef TILED_DIRTY_RECT_TRACKER_ASSERT_SVH
`define TILED_DIRTY_RECT_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF
`define TDRT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define TDRT_ASSERT_IMP(name, ante, cons, msg) \
    `TDRT_ASSERT(name, (ante) |-> (cons), msg)
`define TDRT_ASSERT_NXT(name, ante, cons, msg) \
    `TDRT_ASSERT(name, (ante) |=> (cons), msg)
`else
`define TDRT_ASSERT(name, prop, msg)
`define TDRT_ASSERT_IMP(name, ante, cons, msg)
`define TDRT_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

@@ rtl/tdrt_pkg.sv @@
package tdrt_pkg;

    // Tile geometry
    localparam int TILE_BITS = 6;
    localparam int TILE_SIZE = 1 << TILE_BITS;
    localparam int TX_BITS   = 4;
    localparam int TY_BITS   = 4;
    localparam int ADDR_W    = TX_BITS + TY_BITS;
    localparam int DEPTH     = 1 << ADDR_W;

    // Map coordinates and tile coordinates
    localparam int COORD_W = 13;
    localparam int SIZE_W  = 10;
    localparam int END_W   = COORD_W + 1;
    localparam int TC_W    = END_W - TILE_BITS;

    // Stored entry: x, y, w, h inside the tile
    localparam int OFS_W   = TILE_BITS;
    localparam int LEN_W   = TILE_BITS + 1;
    localparam int ENTRY_W = 2 * OFS_W + 2 * LEN_W;

    // Input tdata layout, lowest field first
    localparam int IN_LEFT_LO   = 0;
    localparam int IN_TOP_LO    = IN_LEFT_LO + COORD_W;
    localparam int IN_WIDTH_LO  = IN_TOP_LO + COORD_W;
    localparam int IN_HEIGHT_LO = IN_WIDTH_LO + SIZE_W;
    localparam int IN_COL_LO    = IN_HEIGHT_LO + SIZE_W;
    localparam int IN_ROW_LO    = IN_COL_LO + TX_BITS;
    localparam int IN_USED_W    = IN_ROW_LO + TY_BITS;
    localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata: x, y, w, h, seam_left, seam_top
    localparam int OUT_USED_W = ENTRY_W + 2;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic MODE_MARK = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    typedef struct packed {
        logic load;
        logic rd;
        logic mark_wr;
        logic take_wr;
    } t_cmd;

    typedef struct packed {
        logic x_last;
        logic y_last;
        logic out_busy;
    } t_sts;

endpackage

@@ rtl/tdrt_ctrl.sv @@
module tdrt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_mode,
    input  tdrt_pkg::t_sts  i_sts,
    output logic            o_ready,
    output tdrt_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MRD  = 5'b00010,
        S_MWR  = 5'b00100,
        S_TRD  = 5'b01000,
        S_TOUT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = (i_mode == tdrt_pkg::MODE_TAKE) ? S_TRD : S_MRD;
                end
            end
            S_MRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MWR;
            end
            S_MWR: begin
                // merge the piece and advance to the next tile
                o_cmd.mark_wr = 1'b1;
                n_state = (i_sts.x_last && i_sts.y_last) ? S_IDLE : S_MRD;
            end
            S_TRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_TOUT;
            end
            S_TOUT: begin
                // hold until the output register is free
                if (!i_sts.out_busy) begin
                    o_cmd.take_wr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`include "tiled_dirty_rect_tracker_assert.svh"

    `TDRT_ASSERT_NXT(a_accept_leaves_idle, i_valid && o_ready, r_state != S_IDLE, "request accepted but idle")
    `TDRT_ASSERT_IMP(a_merge_after_read, o_cmd.mark_wr, $past(o_cmd.rd), "merge without table read")
    `TDRT_ASSERT_IMP(a_take_no_overrun, o_cmd.take_wr, !i_sts.out_busy, "output overwritten")

endmodule

@@ rtl/tdrt_dp.sv @@
module tdrt_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tdrt_pkg::t_cmd                    i_cmd,
    input  logic                              i_mode,
    input  logic [tdrt_pkg::IN_DATA_W-1:0]    i_data,
    input  logic                              i_out_ready,
    output tdrt_pkg::t_sts                    o_sts,
    output logic                              o_out_valid,
    output logic [tdrt_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic                              o_out_user
);

    localparam int OW = tdrt_pkg::OFS_W;
    localparam int LW = tdrt_pkg::LEN_W;
    localparam int TB = tdrt_pkg::TILE_BITS;

    // unpacked request fields
    logic signed [tdrt_pkg::COORD_W-1:0] in_left;
    logic signed [tdrt_pkg::COORD_W-1:0] in_top;
    logic [tdrt_pkg::SIZE_W-1:0]         in_width;
    logic [tdrt_pkg::SIZE_W-1:0]         in_height;
    logic [tdrt_pkg::TX_BITS-1:0]        in_col;
    logic [tdrt_pkg::TY_BITS-1:0]        in_row;
    logic signed [tdrt_pkg::END_W-1:0]   last_x;
    logic signed [tdrt_pkg::END_W-1:0]   last_y;

    assign in_left   = i_data[tdrt_pkg::IN_LEFT_LO +: tdrt_pkg::COORD_W];
    assign in_top    = i_data[tdrt_pkg::IN_TOP_LO +: tdrt_pkg::COORD_W];
    assign in_width  = i_data[tdrt_pkg::IN_WIDTH_LO +: tdrt_pkg::SIZE_W];
    assign in_height = i_data[tdrt_pkg::IN_HEIGHT_LO +: tdrt_pkg::SIZE_W];
    assign in_col    = i_data[tdrt_pkg::IN_COL_LO +: tdrt_pkg::TX_BITS];
    assign in_row    = i_data[tdrt_pkg::IN_ROW_LO +: tdrt_pkg::TY_BITS];

    // last covered pixel: left + (width + 1) - 1
    assign last_x = $signed({in_left[tdrt_pkg::COORD_W-1], in_left})
                  + $signed({{(tdrt_pkg::END_W - tdrt_pkg::SIZE_W){1'b0}}, in_width});
    assign last_y = $signed({in_top[tdrt_pkg::COORD_W-1], in_top})
                  + $signed({{(tdrt_pkg::END_W - tdrt_pkg::SIZE_W){1'b0}}, in_height});

    // walk registers
    logic                             r_is_take;
    logic [tdrt_pkg::ADDR_W-1:0]      r_take_addr;
    logic signed [tdrt_pkg::TC_W-1:0] r_sx, r_ex, r_sy, r_ey, r_px, r_py;
    logic [OW-1:0]                    r_fx, r_fy, r_lx, r_ly;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_take   <= (i_mode == tdrt_pkg::MODE_TAKE);
            r_take_addr <= {in_row, in_col};
            // arithmetic shift gives floor division
            r_sx <= tdrt_pkg::TC_W'(in_left >>> TB);
            r_sy <= tdrt_pkg::TC_W'(in_top >>> TB);
            r_ex <= last_x[tdrt_pkg::END_W-1:TB];
            r_ey <= last_y[tdrt_pkg::END_W-1:TB];
            r_px <= tdrt_pkg::TC_W'(in_left >>> TB);
            r_py <= tdrt_pkg::TC_W'(in_top >>> TB);
            r_fx <= in_left[OW-1:0];
            r_fy <= in_top[OW-1:0];
            r_lx <= last_x[OW-1:0];
            r_ly <= last_y[OW-1:0];
        end else if (i_cmd.mark_wr) begin
            if (r_px == r_ex) begin
                r_px <= r_sx;
                r_py <= r_py + 1'b1;
            end else begin
                r_px <= r_px + 1'b1;
            end
        end
    end

    assign o_sts.x_last = (r_px == r_ex);
    assign o_sts.y_last = (r_py == r_ey);

    // dirty table; tile indices wrap by their low bits
    logic [tdrt_pkg::ADDR_W-1:0]  addr;
    logic [tdrt_pkg::ENTRY_W-1:0] mem [tdrt_pkg::DEPTH];
    logic [tdrt_pkg::DEPTH-1:0]   r_vbits;
    logic [tdrt_pkg::ENTRY_W-1:0] r_rdata;
    logic                         r_rvalid;
    logic [tdrt_pkg::ENTRY_W-1:0] wdata;

    assign addr = r_is_take ? r_take_addr
                            : {r_py[tdrt_pkg::TY_BITS-1:0], r_px[tdrt_pkg::TX_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mark_wr) begin
            mem[addr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata  <= mem[addr];
            r_rvalid <= r_vbits[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits <= '0;
        end else if (i_cmd.mark_wr) begin
            r_vbits[addr] <= 1'b1;
        end else if (i_cmd.take_wr) begin
            r_vbits[addr] <= 1'b0;
        end
    end

    // stored entry fields
    logic [OW-1:0] ox, oy;
    logic [LW-1:0] ow, oh, orx, ory;

    assign ox  = r_rdata[0 +: OW];
    assign oy  = r_rdata[OW +: OW];
    assign ow  = r_rdata[2*OW +: LW];
    assign oh  = r_rdata[2*OW+LW +: LW];
    assign orx = {1'b0, ox} + ow;
    assign ory = {1'b0, oy} + oh;

    // clip the request to the current tile (start offset and exclusive end) and merge it with the stored entry
    logic [OW-1:0] dx, dy, nx, ny;
    logic [LW-1:0] ex_end, ey_end, nrx, nry, nw, nh;

    always_comb begin
        dx     = (r_px == r_sx) ? r_fx : '0;
        dy     = (r_py == r_sy) ? r_fy : '0;
        ex_end = (r_px == r_ex) ? ({1'b0, r_lx} + 1'b1) : LW'(tdrt_pkg::TILE_SIZE);
        ey_end = (r_py == r_ey) ? ({1'b0, r_ly} + 1'b1) : LW'(tdrt_pkg::TILE_SIZE);
        nx     = (r_rvalid && (ox < dx)) ? ox : dx;
        ny     = (r_rvalid && (oy < dy)) ? oy : dy;
        nrx    = (r_rvalid && (orx > ex_end)) ? orx : ex_end;
        nry    = (r_rvalid && (ory > ey_end)) ? ory : ey_end;
        nw     = nrx - {1'b0, nx};
        nh     = nry - {1'b0, ny};
        wdata  = {nh, nw, ny, nx};
    end

    // align the taken rectangle to even start and end
    logic [OW-1:0] ax, ay;
    logic [LW-1:0] aex, aey, aw, ah;

    always_comb begin
        ax  = {ox[OW-1:1], 1'b0};
        ay  = {oy[OW-1:1], 1'b0};
        aex = orx + LW'(orx[0]);
        aey = ory + LW'(ory[0]);
        aw  = aex - {1'b0, ax};
        ah  = aey - {1'b0, ay};
    end

    logic                            r_out_valid;
    logic                            r_out_user;
    logic [tdrt_pkg::OUT_USED_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.take_wr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_wr) begin
            r_out_user <= r_rvalid;
            if (r_rvalid) begin
                r_out_data <= {(ay == '0), (ax == '0), ah, aw, ay, ax};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_user     = r_out_user;
    assign o_out_data     = {{(tdrt_pkg::OUT_DATA_W - tdrt_pkg::OUT_USED_W){1'b0}}, r_out_data};

endmodule

@@ rtl/tiled_dirty_rect_tracker.sv @@
// Channel   Direction  tdata fields (low bit up)                          tuser
// s (in)    slave      rect_left, rect_top, rect_width, rect_height,       mode
//                      tile_col, tile_row
// m (out)   master     out_x, out_y, out_w, out_h, seam_left, seam_top    dirty_valid
//
// A mark request visits each tile it covers in turn:
// each tile is a read then a merge write through the single table port.
// A take request reads its tile, then waits for the output register to free.
// Reset clears all the per-entry valid flops together; no sweep follows.
// The output register lets the next request start while a result is pending.
module tiled_dirty_rect_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // rect_left, rect_top, rect_width, rect_height, tile_col, tile_row
    input  logic [tdrt_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // mode
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // out_x, out_y, out_w, out_h, seam_left, seam_top
    output logic [tdrt_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // dirty_valid
    output logic                             o_m_tuser
);

    tdrt_pkg::t_cmd cmd;
    tdrt_pkg::t_sts sts;

    tdrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_mode  (i_s_tuser),
        .i_sts   (sts),
        .o_ready (o_s_tready),
        .o_cmd   (cmd)
    );

    tdrt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (i_s_tuser),
        .i_data      (i_s_tdata),
        .i_out_ready (i_m_tready),
        .o_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .o_out_user  (o_m_tuser)
    );

endmodule
